// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, constants and the level-of-detail table of the tile index
// sequencer.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Tile geometry.
  localparam int TILE_SIZE    = 242;
  localparam int FINEST_LEVEL = 6;
  localparam int GRID_SPAN    = TILE_SIZE - 2;
  localparam int BV           = TILE_SIZE + 1;

  // Segment counts per level of detail; the step is 2 * (FINEST_LEVEL - level).
  localparam int SEG0 = GRID_SPAN / ((FINEST_LEVEL - 0) * 2);
  localparam int SEG1 = GRID_SPAN / ((FINEST_LEVEL - 1) * 2);
  localparam int SEG2 = GRID_SPAN / ((FINEST_LEVEL - 2) * 2);
  localparam int SEG3 = GRID_SPAN / ((FINEST_LEVEL - 3) * 2);
  localparam int SEG4 = GRID_SPAN / ((FINEST_LEVEL - 4) * 2);
  localparam int SEG5 = GRID_SPAN / ((FINEST_LEVEL - 5) * 2);
  localparam int SEG6 = GRID_SPAN;

  // Section codes, also used as the part of the tile being walked.
  typedef enum logic [2:0] {
    SEC_GRID   = 3'd0,
    SEC_LEFT   = 3'd1,
    SEC_RIGHT  = 3'd2,
    SEC_TOP    = 3'd3,
    SEC_BOTTOM = 3'd4
  } section_t;

  // Phase within one skirt strip.
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_JOIN  = 2'd1,
    PH_FAN   = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  // Derived figures of one level of detail.
  typedef struct packed {
    logic [3:0]  inc;   // grid step
    logic [7:0]  seg;   // segments per side
    logic [8:0]  v;     // vertices per row
    logic [15:0] vv;    // grid vertex count
    logic [15:0] segv;  // first vertex of the last row
  } lvl_info_t;

  // Walk state; acc_v and acc_inc track row * v and row * inc incrementally.
  typedef struct packed {
    section_t    part;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        half;
    logic [3:0]  fan;
    phase_t      phase;
    logic [15:0] acc_v;
    logic [7:0]  acc_inc;
  } seq_state_t;

  // One triangle of the index list.
  typedef struct packed {
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    section_t    section;
    logic        tile_done;
  } tri_t;

  function automatic lvl_info_t mk_lvl(input int step, input int seg);
    lvl_info_t li;
    li.inc  = 4'(step);
    li.seg  = 8'(seg);
    li.v    = 9'(seg + 1);
    li.vv   = 16'((seg + 1) * (seg + 1));
    li.segv = 16'(seg * (seg + 1));
    return li;
  endfunction

  // Level of detail to grid figures; levels above the finest act as the finest.
  function automatic lvl_info_t lvl_lookup(input logic [2:0] lvl);
    lvl_info_t li;
    case (lvl)
      3'd0:    li = mk_lvl(12, SEG0);
      3'd1:    li = mk_lvl(10, SEG1);
      3'd2:    li = mk_lvl(8, SEG2);
      3'd3:    li = mk_lvl(6, SEG3);
      3'd4:    li = mk_lvl(4, SEG4);
      3'd5:    li = mk_lvl(2, SEG5);
      default: li = mk_lvl(1, SEG6);
    endcase
    return li;
  endfunction

endpackage

// ===== rtl/lts_seq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_seq_ctrl
// Holds the level-of-detail register and the walk counters, and advances the
// walk by one triangle on every accepted tick.
// ----------------------------------------------------------------------------
module lts_seq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_wr_data,
  input  logic                   step,
  input  logic                   restart,
  output lts_pkg::seq_state_t    cur_st,
  output lts_pkg::lvl_info_t     lvl
);
  import lts_pkg::*;

  logic [2:0]  level_r;
  seq_state_t  st_r;
  seq_state_t  st_nxt;
  seq_state_t  eff;
  logic [8:0]  col_inc;
  logic [8:0]  row_inc;
  logic [4:0]  fan_inc;

  assign lvl = lvl_lookup(level_r);

  // A restart tick starts from the first grid triangle.
  assign eff    = restart ? '0 : st_r;
  assign cur_st = eff;

  assign col_inc = {1'b0, eff.col} + 9'd1;
  assign row_inc = {1'b0, eff.row} + 9'd1;
  assign fan_inc = {1'b0, eff.fan} + 5'd1;

  // Next walk state after the triangle of the current state.
  always_comb begin
    st_nxt = eff;
    case (eff.part)
      SEC_LEFT, SEC_RIGHT, SEC_TOP, SEC_BOTTOM: begin
        case (eff.phase)
          PH_START: begin
            st_nxt.phase   = PH_JOIN;
            st_nxt.row     = '0;
            st_nxt.acc_v   = '0;
            st_nxt.acc_inc = '0;
            st_nxt.fan     = '0;
          end
          PH_JOIN: begin
            st_nxt.phase = PH_FAN;
            st_nxt.fan   = '0;
          end
          PH_FAN: begin
            st_nxt.fan = fan_inc[3:0];
            if (fan_inc >= {1'b0, lvl.inc}) begin
              st_nxt.fan     = '0;
              st_nxt.row     = row_inc[7:0];
              st_nxt.acc_v   = eff.acc_v + {7'd0, lvl.v};
              st_nxt.acc_inc = eff.acc_inc + {4'd0, lvl.inc};
              st_nxt.phase   = (row_inc >= {1'b0, lvl.seg}) ? PH_END : PH_JOIN;
            end
          end
          default: begin
            st_nxt.phase   = PH_START;
            st_nxt.row     = '0;
            st_nxt.acc_v   = '0;
            st_nxt.acc_inc = '0;
            st_nxt.fan     = '0;
            case (eff.part)
              SEC_LEFT:  st_nxt.part = SEC_RIGHT;
              SEC_RIGHT: st_nxt.part = SEC_TOP;
              SEC_TOP:   st_nxt.part = SEC_BOTTOM;
              default:   st_nxt      = '0;
            endcase
          end
        endcase
      end
      default: begin
        // Inner grid: two triangles per quad, row by row.
        if (!eff.half) begin
          st_nxt.half = 1'b1;
        end else begin
          st_nxt.half = 1'b0;
          st_nxt.col  = col_inc[7:0];
          if (col_inc >= {1'b0, lvl.seg}) begin
            st_nxt.col     = '0;
            st_nxt.row     = row_inc[7:0];
            st_nxt.acc_v   = eff.acc_v + {7'd0, lvl.v};
            st_nxt.acc_inc = eff.acc_inc + {4'd0, lvl.inc};
            if (row_inc >= {1'b0, lvl.seg}) begin
              st_nxt.row     = '0;
              st_nxt.acc_v   = '0;
              st_nxt.acc_inc = '0;
              st_nxt.part    = SEC_LEFT;
              st_nxt.phase   = PH_START;
              st_nxt.fan     = '0;
            end
          end
        end
      end
    endcase
  end

  // Level register and walk state; a level write restarts the tile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 3'(FINEST_LEVEL);
      st_r    <= '0;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
      st_r    <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  // The running products must match the row counter.
  a_acc_v: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.acc_v == 16'({7'd0, st_r.row} * {7'd0, lvl.v}))
    else $error("row base out of step with row counter");

  a_acc_inc: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.acc_inc == 8'({4'd0, st_r.row} * {8'd0, lvl.inc}))
    else $error("border offset out of step with row counter");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fan < lvl.inc && st_r.col < lvl.seg && st_r.row <= lvl.seg)
    else $error("walk counter beyond its range");

endmodule

// ===== rtl/lts_tri_calc.sv =====
// ----------------------------------------------------------------------------
// lts_tri_calc
// Builds the three vertex indices, the section and the end-of-tile flag of
// the triangle that the current walk state points at.
// ----------------------------------------------------------------------------
module lts_tri_calc (
  input  lts_pkg::seq_state_t st,
  input  lts_pkg::lvl_info_t  lvl,
  output lts_pkg::tri_t       tri_out
);
  import lts_pkg::*;

  logic [15:0] ga;
  logic [15:0] gb;
  logic [15:0] base;
  logic [15:0] bi;
  logic [15:0] bv1;
  logic [15:0] bv2;
  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] fv;
  logic [15:0] seg16;
  logic [15:0] s16;

  assign seg16 = {8'd0, lvl.seg};
  assign s16   = {8'd0, st.row};

  // Grid quad corners.
  assign ga = {8'd0, st.col} + st.acc_v;
  assign gb = ga + {7'd0, lvl.v};

  // Border vertex base of the strip.
  always_comb begin
    case (st.part)
      SEC_RIGHT:  base = lvl.vv + 16'(BV);
      SEC_TOP:    base = lvl.vv + 16'(2 * BV);
      SEC_BOTTOM: base = lvl.vv + 16'(3 * BV);
      default:    base = lvl.vv;
    endcase
  end

  assign bi  = base + 16'd1 + {8'd0, st.acc_inc};
  assign bv2 = base + 16'(BV - 2);
  assign bv1 = base + 16'(BV - 1);
  assign fv  = bi + {12'd0, st.fan};

  // Grid vertices on the edge that the strip joins.
  always_comb begin
    case (st.part)
      SEC_LEFT: begin
        lo = st.acc_v;
        hi = st.acc_v + {7'd0, lvl.v};
      end
      SEC_RIGHT: begin
        lo = seg16 + st.acc_v;
        hi = seg16 + st.acc_v + {7'd0, lvl.v};
      end
      SEC_TOP: begin
        lo = s16;
        hi = s16 + 16'd1;
      end
      default: begin
        lo = lvl.segv + s16;
        hi = lvl.segv + s16 + 16'd1;
      end
    endcase
  end

  // Triangle selection.
  always_comb begin
    tri_out.section   = (st.part == SEC_LEFT || st.part == SEC_RIGHT ||
                         st.part == SEC_TOP || st.part == SEC_BOTTOM) ? st.part : SEC_GRID;
    tri_out.tile_done = (st.part == SEC_BOTTOM) && (st.phase == PH_END);
    tri_out.corner_a  = ga;
    tri_out.corner_b  = gb;
    tri_out.corner_c  = ga + 16'd1;
    if (tri_out.section == SEC_GRID) begin
      if (st.half) begin
        tri_out.corner_a = gb;
        tri_out.corner_b = gb + 16'd1;
      end
    end else begin
      case (st.phase)
        PH_START: begin
          tri_out.corner_a = base;
          case (st.part)
            SEC_LEFT: begin
              tri_out.corner_b = base + 16'd1; tri_out.corner_c = '0;
            end
            SEC_RIGHT: begin
              tri_out.corner_b = seg16;        tri_out.corner_c = base + 16'd1;
            end
            SEC_TOP: begin
              tri_out.corner_b = '0;           tri_out.corner_c = base + 16'd1;
            end
            default: begin
              tri_out.corner_b = base + 16'd1; tri_out.corner_c = lvl.segv;
            end
          endcase
        end
        PH_JOIN: begin
          tri_out.corner_a = lo;
          if (st.part == SEC_LEFT || st.part == SEC_BOTTOM) begin
            tri_out.corner_b = bi;
            tri_out.corner_c = hi;
          end else begin
            tri_out.corner_b = hi;
            tri_out.corner_c = bi;
          end
        end
        PH_FAN: begin
          tri_out.corner_a = fv;
          if (st.part == SEC_LEFT || st.part == SEC_BOTTOM) begin
            tri_out.corner_b = fv + 16'd1;
            tri_out.corner_c = hi;
          end else begin
            tri_out.corner_b = hi;
            tri_out.corner_c = fv + 16'd1;
          end
        end
        default: begin
          case (st.part)
            SEC_LEFT: begin
              tri_out.corner_a = bv2; tri_out.corner_b = bv1; tri_out.corner_c = lvl.segv;
            end
            SEC_RIGHT: begin
              tri_out.corner_a = bv1; tri_out.corner_b = bv2;
              tri_out.corner_c = lvl.vv - 16'd1;
            end
            SEC_TOP: begin
              tri_out.corner_a = bv2; tri_out.corner_b = seg16; tri_out.corner_c = bv1;
            end
            default: begin
              tri_out.corner_a = lvl.vv - 16'd1; tri_out.corner_b = bv2;
              tri_out.corner_c = bv1;
            end
          endcase
        end
      endcase
    end
  end

endmodule

// ===== rtl/lts_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lts_out_fifo
// Two-entry result buffer; while it holds one triangle it still takes one more
// as the consumer stalls, and its ready depends on its own fill level only.
// ----------------------------------------------------------------------------
module lts_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lts_pkg::tri_t  push_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output lts_pkg::tri_t  head
);
  import lts_pkg::*;

  tri_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_pop;

  assign full   = (count_r == 2'd2);
  assign valid  = (count_r != 2'd0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/lod_tile_index_sequencer.sv =====
// ----------------------------------------------------------------------------
// lod_tile_index_sequencer
// Terrain tile triangle index sequencer, one triangle per input tick.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one triangle of the tile's index list.
// One transfer is accepted per clock cycle while the result buffer is not
// full; its triangle is built from the walk counters in the same cycle and
// appears on the output in the next cycle from a two-entry result buffer.
// In steady flow the buffer holds one triangle, so a stalled output cycle
// still accepts one more tick, and the input is then held off while the
// buffer is full. The walk counters keep running row and border offsets that
// grow by addition, which holds the index path to a few 16-bit adders. A
// write of the level of detail takes effect at once and restarts the tile at
// its first grid triangle; it is meant to be done while no result is pending.
module lod_tile_index_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // Level of detail register.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // Tick stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart, [7:1] zero
  // Triangle stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c
  output logic [2:0]  out_tuser,   // [2:0] section
  output logic        out_tlast    // tile_done
);
  import lts_pkg::*;

  seq_state_t cur_st;
  lvl_info_t  lvl;
  tri_t       tri_new;
  tri_t       tri_head;
  logic       in_xfer;
  logic       buf_full;

  assign in_tready = !buf_full;
  assign in_xfer   = in_tvalid && in_tready;

  // Walk counters and level register.
  lts_seq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (in_xfer),
    .restart     (in_tdata[0]),
    .cur_st      (cur_st),
    .lvl         (lvl)
  );

  // Index generation.
  lts_tri_calc u_calc (
    .st      (cur_st),
    .lvl     (lvl),
    .tri_out (tri_new)
  );

  // Result buffer.
  lts_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (tri_new),
    .pop       (out_tready),
    .full      (buf_full),
    .valid     (out_tvalid),
    .head      (tri_head)
  );

  assign out_tdata = {tri_head.corner_c, tri_head.corner_b, tri_head.corner_a};
  assign out_tuser = tri_head.section;
  assign out_tlast = tri_head.tile_done;

  // The end of the tile is always the bottom strip's end triangle.
  a_done_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == SEC_BOTTOM)
    else $error("tile end flagged outside the bottom strip");

  // A level write puts the walk back at the first grid triangle.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> cur_st.part == SEC_GRID && cur_st.row == 8'd0 &&
                  cur_st.col == 8'd0 && !cur_st.half)
    else $error("level write did not restart the tile");

  // Every accepted tick leaves a triangle ready in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid)
    else $error("accepted tick produced no triangle");

endmodule

// ===== tb/tb_lod_tile_index_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lod_tile_index_sequencer
// Self-checking regression of the terrain tile triangle index sequencer.
// ----------------------------------------------------------------------------
// A directed table covers reset values, restarts, level-of-detail writes and
// the level above the finest. A long walk at the coarsest level then runs
// through the whole inner grid and the whole left skirt strip into the right
// one, followed by short noisy phases at random levels that restart at random.
// Every triangle is checked field by field against a local model of the walk,
// or against the typed-in triangle of a table row.
module tb_lod_tile_index_sequencer;
  import lts_pkg::*;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles without any transfer
  localparam int TAIL_CYCLES = 20;    // settle time after the last triangle

  // Receiver stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_mode_t;

  // One row of the directed table; the triangle is typed in only where
  // it can be read off at a glance.
  typedef struct {
    bit          wr;       // write the level before this tick
    logic [2:0]  lvl;
    bit          restart;
    bit          typed;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    section_t    sec;
    bit          done;
  } steer_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c
  logic [2:0]  out_tuser;   // [2:0] section
  logic        out_tlast;   // tile_done

  // Model of the tile walk.
  logic [2:0]  w_level;
  section_t    w_part;
  logic [7:0]  w_row;
  logic [7:0]  w_col;
  logic        w_half;
  logic [3:0]  w_fan;
  phase_t      w_phase;

  tri_t        pending_tris[$];
  tri_t        want;
  steer_row_t  steer_rows[22];
  int          bad_fields = 0;
  int          tris_seen = 0;
  int          idle_cycles = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          nogap_left = 0;
  int          burst_left = 0;
  bit          rx_fast = 1'b0;

  lod_tile_index_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Back to the first grid triangle.
  function automatic void restart_walk();
    w_part  = SEC_GRID;
    w_row   = '0;
    w_col   = '0;
    w_half  = 1'b0;
    w_fan   = '0;
    w_phase = PH_START;
  endfunction

  // Grid step of a level; levels above the finest use step 1.
  function automatic int level_step(input logic [2:0] lvl);
    return (int'(lvl) >= FINEST_LEVEL) ? 1 : (FINEST_LEVEL - int'(lvl)) * 2;
  endfunction

  // Next triangle of the walk; advances the walk state.
  function automatic tri_t next_triangle(input logic restart);
    tri_t     t;
    int       inc, seg, v, base, s, lo, hi, bi, f, a, b;
    int       ta, tb, tc;
    section_t sec;
    t.tile_done = 1'b0;
    if (restart) restart_walk();
    inc = level_step(w_level);
    seg = (TILE_SIZE - 2) / inc;
    v   = seg + 1;
    sec = w_part;
    if (sec == SEC_GRID) begin
      // Inner grid: two triangles per quad, row by row.
      a = int'(w_col) + v * int'(w_row);
      b = a + v;
      if (!w_half) begin
        ta = a; tb = b; tc = a + 1;
        w_half = 1'b1;
      end else begin
        ta = b; tb = b + 1; tc = a + 1;
        w_half = 1'b0;
        w_col++;
        if (int'(w_col) >= seg) begin
          w_col = '0;
          w_row++;
          if (int'(w_row) >= seg) begin
            w_row   = '0;
            w_part  = SEC_LEFT;
            w_phase = PH_START;
            w_fan   = '0;
          end
        end
      end
    end else begin
      // Skirt strip: border vertices follow the grid, one strip after another.
      base = v * v + (int'(sec) - 1) * BV;
      s    = int'(w_row);
      bi   = base + 1 + s * inc;
      case (sec)
        SEC_LEFT:  lo = s * v;
        SEC_RIGHT: lo = seg + s * v;
        SEC_TOP:   lo = s;
        default:   lo = seg * v + s;
      endcase
      hi = (sec == SEC_LEFT || sec == SEC_RIGHT) ? lo + v : lo + 1;
      case (w_phase)
        PH_START: begin
          case (sec)
            SEC_LEFT:  begin ta = base; tb = base + 1; tc = 0;       end
            SEC_RIGHT: begin ta = base; tb = seg;      tc = base + 1; end
            SEC_TOP:   begin ta = base; tb = 0;        tc = base + 1; end
            default:   begin ta = base; tb = base + 1; tc = seg * v; end
          endcase
          w_phase = PH_JOIN;
          w_row   = '0;
          w_fan   = '0;
        end
        PH_JOIN: begin
          if (sec == SEC_LEFT || sec == SEC_BOTTOM) begin
            ta = lo; tb = bi; tc = hi;
          end else begin
            ta = lo; tb = hi; tc = bi;
          end
          w_phase = PH_FAN;
          w_fan   = '0;
        end
        PH_FAN: begin
          f = bi + int'(w_fan);
          if (sec == SEC_LEFT || sec == SEC_BOTTOM) begin
            ta = f; tb = f + 1; tc = hi;
          end else begin
            ta = f; tb = hi; tc = f + 1;
          end
          w_fan++;
          if (int'(w_fan) >= inc) begin
            w_fan = '0;
            w_row++;
            w_phase = (int'(w_row) >= seg) ? PH_END : PH_JOIN;
          end
        end
        default: begin
          case (sec)
            SEC_LEFT:  begin ta = base + BV - 2; tb = base + BV - 1; tc = seg * v;   end
            SEC_RIGHT: begin ta = base + BV - 1; tb = base + BV - 2; tc = v * v - 1; end
            SEC_TOP:   begin ta = base + BV - 2; tb = seg;           tc = base + BV - 1; end
            default:   begin ta = v * v - 1;     tb = base + BV - 2; tc = base + BV - 1; end
          endcase
          w_phase = PH_START;
          w_row   = '0;
          w_fan   = '0;
          if (sec == SEC_BOTTOM) begin
            t.tile_done = 1'b1;
            restart_walk();
          end else begin
            w_part = section_t'(int'(sec) + 1);
          end
        end
      endcase
    end
    t.corner_a = 16'(ta);
    t.corner_b = 16'(tb);
    t.corner_c = 16'(tc);
    t.section  = sec;
    return t;
  endfunction

  task automatic flag_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch on %s of triangle %0d: got %0d, expected %0d",
             field, tris_seen, got, exp_val);
    bad_fields++;
  endtask

  // Offer one tick and hold it until the transfer; record its triangle.
  task automatic send_tick(input logic restart, input bit typed, input tri_t typed_tri);
    tri_t guess;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!in_tready);
    guess = next_triangle(restart);
    pending_tris.insert(pending_tris.size(), typed ? typed_tri : guess);
  endtask

  // Stop offering and wait for every outstanding triangle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
  endtask

  // Level of detail write, done only while the block is idle.
  task automatic write_level(input logic [2:0] lvl);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    w_level = lvl;
    restart_walk();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sender bursts: random burst lengths, now and then a long one, and
  // random gaps in between.
  task automatic pace_sender();
    int gap;
    if (nogap_left > 0) begin
      nogap_left--;
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 24);
    gap = $urandom_range(1, 8);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // One phase at a fixed level; restarts come with the given rate per mille.
  task automatic run_walk(input logic [2:0] lvl, input int count, input int restart_pm,
                          input bit paced, input int hold_at, input int pause_at);
    write_level(lvl);
    rx_fast = !paced;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      if (i == hold_at) begin
        hold_requests++;
        nogap_left = 80;
      end
      send_tick($urandom_range(1, 1000) <= restart_pm, 1'b0, '0);
      if (paced) pace_sender();
    end
  endtask

  // Receiver: own stall pattern, plus the long hold-off on request.
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       rx_cycle;
    rx_mode    = RX_OPEN;
    mode_left  = 0;
    rx_cycle   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_fast) begin
        out_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 160);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:          out_tready <= 1'b1;
          RX_COIN:          out_tready <= 1'($urandom_range(0, 1));
          RX_THREE_OF_FOUR: out_tready <= (rx_cycle % 4) != 0;
          default:          out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Check every triangle transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tris.size() == 0) begin
        flag_mismatch("unexpected triangle", out_tdata[15:0], 0);
      end else begin
        want = pending_tris.pop_front();
        if (out_tdata[15:0] !== want.corner_a)
          flag_mismatch("corner_a", out_tdata[15:0], want.corner_a);
        if (out_tdata[31:16] !== want.corner_b)
          flag_mismatch("corner_b", out_tdata[31:16], want.corner_b);
        if (out_tdata[47:32] !== want.corner_c)
          flag_mismatch("corner_c", out_tdata[47:32], want.corner_c);
        if (out_tuser !== want.section)
          flag_mismatch("section", out_tuser, want.section);
        if (out_tlast !== want.tile_done)
          flag_mismatch("tile_done", out_tlast, want.tile_done);
      end
      tris_seen++;
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("lod_tile_index_sequencer regression: fail");
    $finish;
  end

  // Main sequence.
  initial begin
    tri_t typed_tri;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    w_level     = 3'(FINEST_LEVEL);
    restart_walk();

    // wr, level, restart, typed, corner a, b, c, section, tile_done
    steer_rows = '{
      '{0, 3'd6, 0, 1, 0,   241, 1, SEC_GRID, 0},  // first triangle after reset
      '{0, 3'd6, 0, 1, 241, 242, 1, SEC_GRID, 0},
      '{0, 3'd6, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{0, 3'd6, 1, 1, 0,   241, 1, SEC_GRID, 0},  // restart
      '{0, 3'd6, 1, 1, 0,   241, 1, SEC_GRID, 0},  // restart twice in a row
      '{0, 3'd6, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{1, 3'd0, 0, 1, 0,   21,  1, SEC_GRID, 0},  // coarsest level
      '{0, 3'd0, 0, 1, 21,  22,  1, SEC_GRID, 0},
      '{0, 3'd0, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{0, 3'd0, 1, 1, 0,   21,  1, SEC_GRID, 0},
      '{0, 3'd0, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{1, 3'd0, 0, 1, 0,   21,  1, SEC_GRID, 0},  // same level written again
      '{1, 3'd7, 0, 1, 0,   241, 1, SEC_GRID, 0},  // above the finest level
      '{0, 3'd7, 0, 1, 241, 242, 1, SEC_GRID, 0},
      '{1, 3'd5, 0, 1, 0,   121, 1, SEC_GRID, 0},
      '{0, 3'd5, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{1, 3'd1, 0, 1, 0,   25,  1, SEC_GRID, 0},
      '{1, 3'd2, 0, 1, 0,   31,  1, SEC_GRID, 0},
      '{1, 3'd3, 0, 1, 0,   41,  1, SEC_GRID, 0},
      '{1, 3'd4, 0, 1, 0,   61,  1, SEC_GRID, 0},
      '{0, 3'd4, 0, 0, 0,   0,   0, SEC_GRID, 0},
      '{0, 3'd4, 1, 1, 0,   61,  1, SEC_GRID, 0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (steer_rows[i]) begin
      if (steer_rows[i].wr) write_level(steer_rows[i].lvl);
      typed_tri.corner_a  = steer_rows[i].a;
      typed_tri.corner_b  = steer_rows[i].b;
      typed_tri.corner_c  = steer_rows[i].c;
      typed_tri.section   = steer_rows[i].sec;
      typed_tri.tile_done = steer_rows[i].done;
      send_tick(steer_rows[i].restart, steer_rows[i].typed, typed_tri);
      pace_sender();
    end

    // The whole coarse grid and left strip, running into the right strip,
    // with the long hold-off and a full drain inside.
    run_walk(3'd0, 1070, 0, 1'b1, 300, 700);
    // Short phases at random levels with frequent restarts.
    repeat (2) run_walk(3'($urandom_range(0, 7)), $urandom_range(10, 20), 250, 1'b1, -1, -1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_fields == 0 && pending_tris.size() == 0)
      $display("lod_tile_index_sequencer regression: pass");
    else
      $display("lod_tile_index_sequencer regression: fail");
    $finish;
  end

endmodule
